>>> rtl/keyed_sine_tone_generator_assert.svh
// Assertion macros shared by the tone generator RTL.
`ifndef KEYED_SINE_TONE_GENERATOR_ASSERT_SVH
`define KEYED_SINE_TONE_GENERATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KSTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define KSTG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/kstg_pkg.sv
// Types, constants and tables for the keyed sine tone generator.
package kstg_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_COUNT   = 7;
  localparam int CLK_W       = 27;
  localparam int KEY_W       = KEY_COUNT;
  localparam int DAC_W       = 6;
  localparam int PHASE_W     = 6;
  localparam int PERIOD_W    = 12;
  localparam int DIVISOR_W   = 16;
  localparam int NOTE_W      = 3;

  localparam logic [CLK_W-1:0]    CLOCK_HZ_RESET = 27'd16000000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 12'hFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN     = 12'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } kstg_state_e;

  // Divisor per note: table depth times the note frequency
  localparam logic [DIVISOR_W-1:0] NOTE_DIVISOR [KEY_COUNT] = '{
    16'(TABLE_DEPTH * 523), 16'(TABLE_DEPTH * 587), 16'(TABLE_DEPTH * 659),
    16'(TABLE_DEPTH * 698), 16'(TABLE_DEPTH * 784), 16'(TABLE_DEPTH * 880),
    16'(TABLE_DEPTH * 988)
  };

  // One period of a sine, offset to unsigned six-bit samples
  localparam logic [DAC_W-1:0] SINE_ROM [TABLE_DEPTH] = '{
    6'd32, 6'd35, 6'd38, 6'd41, 6'd44, 6'd47, 6'd49, 6'd52,
    6'd54, 6'd56, 6'd58, 6'd59, 6'd61, 6'd62, 6'd62, 6'd63,
    6'd63, 6'd63, 6'd62, 6'd62, 6'd61, 6'd59, 6'd58, 6'd56,
    6'd54, 6'd52, 6'd49, 6'd47, 6'd44, 6'd41, 6'd38, 6'd35,
    6'd32, 6'd29, 6'd26, 6'd23, 6'd20, 6'd17, 6'd15, 6'd12,
    6'd10, 6'd8,  6'd6,  6'd5,  6'd3,  6'd2,  6'd2,  6'd1,
    6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd5,  6'd6,  6'd8,
    6'd10, 6'd12, 6'd15, 6'd17, 6'd20, 6'd23, 6'd26, 6'd29
  };

  // Lowest pressed key picks the note; the top key is the fallback
  function automatic logic [NOTE_W-1:0] key_to_note(input logic [KEY_W-1:0] keys);
    logic [NOTE_W-1:0] idx;
    idx = NOTE_W'(KEY_COUNT - 1);
    for (int i = KEY_COUNT - 2; i >= 0; i--) begin
      if (keys[i]) begin
        idx = NOTE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/kstg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module kstg_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [kstg_pkg::CLK_W-1:0]      dividend_i,
  input  logic [kstg_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [kstg_pkg::CLK_W-1:0]      quot_o
);
  import kstg_pkg::*;

  localparam int CNT_W = $clog2(CLK_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] div_q, div_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [CLK_W-1:0]     quot_q, quot_d;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and try a subtraction
  assign trial = {rem_q, quot_q[CLK_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quot_d = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
      quot_d = {quot_q[CLK_W-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control under reset, datapath free-running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`include "keyed_sine_tone_generator_assert.svh"

  `KSTG_ASSERT(div_start_idle, start_i |-> !busy_q, "divider started while busy")
  `KSTG_ASSERT(div_done_pulse, done_q |=> !done_q, "divider done held for two cycles")
  `KSTG_NEVER(div_done_busy, done_q && busy_q, "divider done while still busy")

endmodule

>>> rtl/keyed_sine_tone_generator.sv
// Top level of the keyed sine tone generator.
//
// Each input item is one system tick carrying the seven key bits (keys_i).
// An item is taken when in_valid_i is high and in_stall_o is low; each item
// gives exactly one result item on dac_level_o, playing_o, sample_strobe_o,
// shown by out_valid_o and taken when out_stall_i is low.
// A tick that is not a key press goes straight to the output register: its
// result stands there on the next cycle and a new item is taken in the same
// cycle, so such ticks run at one per clock while the receiver does not stall.
// A key press while no note is held runs the note period division through
// the restoring divider, one quotient bit per cycle for all 27 quotient bits;
// ST_DIV then takes the clamped quotient as the period and ST_LOAD loads the
// result once the output slot frees, with in_stall_o high throughout.
// cfg_we_i writes cfg_wdata_i to the clock frequency register; the value is
// used at the next key press.
// While the receiver stalls, the output register holds its item and
// in_stall_o stays high until the slot frees.
// Reset (rst_ni low, asynchronous) drops the note, clears period, counter,
// phase and the held DAC level, and sets the clock frequency to 16 MHz.
module keyed_sine_tone_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kstg_pkg::CLK_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kstg_pkg::KEY_W-1:0]  keys_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kstg_pkg::DAC_W-1:0]  dac_level_o,
  output logic                        playing_o,
  output logic                        sample_strobe_o
);
  import kstg_pkg::*;

  kstg_state_e         state_q, state_d;
  logic [CLK_W-1:0]    clock_hz_q;
  logic                note_latched_q, note_latched_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [PERIOD_W-1:0] tick_count_q, tick_count_d;
  logic [PERIOD_W-1:0] tick_next;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [DAC_W-1:0]    dac_hold_q, dac_hold_d;
  logic                out_valid_q, out_valid_d;
  logic [DAC_W-1:0]    out_dac_q, out_dac_d;
  logic                out_play_q, out_play_d;
  logic                out_strobe_q, out_strobe_d;
  logic                out_load;
  logic                slot_free;
  logic                accept;
  logic                press;
  logic                div_start;
  logic                div_done;
  logic [CLK_W-1:0]    div_quot;
  logic [PERIOD_W-1:0] period_sat;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign press      = !note_latched_q && (keys_i != '0);
  assign tick_next  = tick_count_q + PERIOD_W'(1);

  // Clamp the quotient into the period range
  always_comb begin
    if (div_quot[CLK_W-1:PERIOD_W] != '0) begin
      period_sat = PERIOD_MAX;
    end else if (div_quot[PERIOD_W-1:0] == '0) begin
      period_sat = PERIOD_MIN;
    end else begin
      period_sat = div_quot[PERIOD_W-1:0];
    end
  end

  kstg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clock_hz_q),
    .divisor_i  (NOTE_DIVISOR[key_to_note(keys_i)]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequence ticks, presses and result loads
  always_comb begin
    state_d        = state_q;
    note_latched_d = note_latched_q;
    period_d       = period_q;
    tick_count_d   = tick_count_q;
    phase_d        = phase_q;
    dac_hold_d     = dac_hold_q;
    div_start      = 1'b0;
    out_load       = 1'b0;
    out_strobe_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (press) begin
            div_start      = 1'b1;
            tick_count_d   = '0;
            note_latched_d = 1'b1;
            state_d        = ST_DIV;
          end else begin
            out_load = 1'b1;
            if (note_latched_q && (keys_i == '0)) begin
              note_latched_d = 1'b0;
            end else if (note_latched_q) begin
              if (tick_next >= period_q) begin
                tick_count_d = '0;
                phase_d      = phase_q + PHASE_W'(1);
                dac_hold_d   = SINE_ROM[phase_d];
                out_strobe_d = 1'b1;
              end else begin
                tick_count_d = tick_next;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          period_d = period_sat;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_dac_d   = dac_hold_d;
    out_play_d  = note_latched_d;
    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // State, configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      clock_hz_q     <= CLOCK_HZ_RESET;
      note_latched_q <= 1'b0;
      period_q       <= '0;
      tick_count_q   <= '0;
      phase_q        <= '0;
      dac_hold_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      note_latched_q <= note_latched_d;
      period_q       <= period_d;
      tick_count_q   <= tick_count_d;
      phase_q        <= phase_d;
      dac_hold_q     <= dac_hold_d;
      out_valid_q    <= out_valid_d;
      if (cfg_we_i) begin
        clock_hz_q <= cfg_wdata_i;
      end
    end
  end

  // Output item register, loaded only when the slot frees
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dac_q    <= out_dac_d;
      out_play_q   <= out_play_d;
      out_strobe_q <= out_strobe_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dac_level_o     = out_dac_q;
  assign playing_o       = out_play_q;
  assign sample_strobe_o = out_strobe_q;

`include "keyed_sine_tone_generator_assert.svh"

  `KSTG_ASSERT(press_starts_div, (accept && press) |=> (state_q == ST_DIV),
               "key press did not start the period division")
  `KSTG_ASSERT(period_nonzero, (note_latched_q && (state_q == ST_IDLE)) |-> (period_q != '0),
               "note held with a zero period")
  `KSTG_ASSERT(count_below_period,
               (note_latched_q && (state_q == ST_IDLE)) |-> (tick_count_q < period_q),
               "tick counter reached the period")
  `KSTG_NEVER(strobe_when_silent, out_valid_q && out_strobe_q && !out_play_q,
              "sample strobe without a note playing")

endmodule
